### rtl/core/slt_pkg.sv
// Shared types, token and character codes, and the keyword table of the source scanner.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package slt_pkg;

  localparam int unsigned KeywordCharsDefault = 6;
  localparam int unsigned PositionBitsDefault = 16;
  localparam int unsigned MaxRes              = 4;
  localparam int unsigned NumKeywords         = 17;

  // result kinds
  localparam logic [1:0] RK_PAYLOAD = 2'd0;
  localparam logic [1:0] RK_TOKEN   = 2'd1;
  localparam logic [1:0] RK_ERROR   = 2'd2;

  // token types
  localparam logic [5:0] T_IDENT   = 6'd0;
  localparam logic [5:0] T_INT     = 6'd1;
  localparam logic [5:0] T_DOUBLE  = 6'd2;
  localparam logic [5:0] T_STRING  = 6'd3;
  localparam logic [5:0] T_MINUS   = 6'd4;
  localparam logic [5:0] T_PLUS    = 6'd5;
  localparam logic [5:0] T_COMMA   = 6'd6;
  localparam logic [5:0] T_RBR     = 6'd7;
  localparam logic [5:0] T_LBR     = 6'd8;
  localparam logic [5:0] T_STAR    = 6'd9;
  localparam logic [5:0] T_SLASH   = 6'd10;
  localparam logic [5:0] T_MORE    = 6'd11;
  localparam logic [5:0] T_LESS    = 6'd12;
  localparam logic [5:0] T_MORE_EQ = 6'd13;
  localparam logic [5:0] T_LESS_EQ = 6'd14;
  localparam logic [5:0] T_EQUAL   = 6'd15;
  localparam logic [5:0] T_EQUAL2  = 6'd16;
  localparam logic [5:0] T_NOT_EQ  = 6'd17;
  localparam logic [5:0] T_NEWLINE = 6'd18;
  localparam logic [5:0] T_EOF     = 6'd19;
  localparam logic [5:0] T_KEY0    = 6'd20;

  // characters, bit 8 marks end of input
  localparam logic [8:0] C_END    = 9'h100;
  localparam logic [8:0] C_NL     = 9'h00A;
  localparam logic [8:0] C_TAB    = 9'h009;
  localparam logic [8:0] C_SPACE  = 9'h020;
  localparam logic [8:0] C_BANG   = 9'h021;
  localparam logic [8:0] C_QUOTE  = 9'h022;
  localparam logic [8:0] C_HASH   = 9'h023;
  localparam logic [8:0] C_LPAR   = 9'h028;
  localparam logic [8:0] C_RPAR   = 9'h029;
  localparam logic [8:0] C_STAR   = 9'h02A;
  localparam logic [8:0] C_PLUS   = 9'h02B;
  localparam logic [8:0] C_COMMA  = 9'h02C;
  localparam logic [8:0] C_MINUS  = 9'h02D;
  localparam logic [8:0] C_DOT    = 9'h02E;
  localparam logic [8:0] C_SLASH  = 9'h02F;
  localparam logic [8:0] C_LT     = 9'h03C;
  localparam logic [8:0] C_EQ     = 9'h03D;
  localparam logic [8:0] C_GT     = 9'h03E;
  localparam logic [8:0] C_QMARK  = 9'h03F;
  localparam logic [8:0] C_UPPERE = 9'h045;
  localparam logic [8:0] C_BSLASH = 9'h05C;
  localparam logic [8:0] C_UNDER  = 9'h05F;
  localparam logic [8:0] C_B      = 9'h062;
  localparam logic [8:0] C_D      = 9'h064;
  localparam logic [8:0] C_E      = 9'h065;
  localparam logic [8:0] C_G      = 9'h067;
  localparam logic [8:0] C_I      = 9'h069;
  localparam logic [8:0] C_N      = 9'h06E;
  localparam logic [8:0] C_S      = 9'h073;
  localparam logic [8:0] C_T      = 9'h074;
  localparam logic [8:0] C_X      = 9'h078;

  // keyword text, first character in the top byte
  localparam logic [2:0] KW_LEN [NumKeywords] = '{
    3'd3, 3'd2, 3'd4, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4, 3'd5,
    3'd6, 3'd6, 3'd6, 3'd5, 3'd6, 3'd6, 3'd3, 3'd3
  };
  localparam logic [47:0] KW_TXT [NumKeywords] = '{
    {"def", 24'h0}, {"do", 32'h0}, {"else", 16'h0}, {"end", 24'h0},
    {"if", 32'h0}, {"not", 24'h0}, {"nil", 24'h0}, {"then", 16'h0},
    {"while", 8'h0}, 48'("inputs"), 48'("inputi"), 48'("inputf"),
    {"print", 8'h0}, 48'("length"), 48'("substr"), {"ord", 24'h0}, {"chr", 24'h0}
  };

  typedef enum logic [31:0] {
    S_START     = 32'd1 << 0,
    S_IDENT     = 32'd1 << 1,
    S_IDCHECK   = 32'd1 << 2,
    S_LESS      = 32'd1 << 3,
    S_MORE      = 32'd1 << 4,
    S_NOTEQ     = 32'd1 << 5,
    S_LCOMMENT  = 32'd1 << 6,
    S_INT       = 32'd1 << 7,
    S_DOT       = 32'd1 << 8,
    S_FRAC      = 32'd1 << 9,
    S_EXPMARK   = 32'd1 << 10,
    S_EXPSIGN   = 32'd1 << 11,
    S_EXP       = 32'd1 << 12,
    S_STRING    = 32'd1 << 13,
    S_ESC       = 32'd1 << 14,
    S_HEX       = 32'd1 << 15,
    S_HEX1      = 32'd1 << 16,
    S_EQUAL     = 32'd1 << 17,
    S_BC_B      = 32'd1 << 18,
    S_BC_E      = 32'd1 << 19,
    S_BC_G      = 32'd1 << 20,
    S_BC_I      = 32'd1 << 21,
    S_BC_N      = 32'd1 << 22,
    S_BC_SPACE  = 32'd1 << 23,
    S_BC_BODY   = 32'd1 << 24,
    S_BC_ENDCHK = 32'd1 << 25,
    S_BC_E2     = 32'd1 << 26,
    S_BC_N2     = 32'd1 << 27,
    S_BC_D2     = 32'd1 << 28,
    S_BC_SPACE2 = 32'd1 << 29,
    S_BC_TAIL   = 32'd1 << 30,
    S_DONE      = 32'd1 << 31
  } scan_state_e;

  typedef struct packed {
    logic [1:0]  rkind;
    logic [5:0]  ttype;
    logic [7:0]  vbyte;
    logic [15:0] line;
    logic [15:0] col;
    logic        last;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0] rec;
    logic [2:0]        count;
  } res_bundle_t;

  function automatic logic is_digit(logic [8:0] c);
    return !c[8] && c[7:0] >= 8'h30 && c[7:0] <= 8'h39;
  endfunction

  function automatic logic is_lower(logic [8:0] c);
    return !c[8] && c[7:0] >= 8'h61 && c[7:0] <= 8'h7A;
  endfunction

  function automatic logic is_word(logic [8:0] c);
    return is_lower(c) || is_digit(c) || c == C_UNDER ||
           (!c[8] && c[7:0] >= 8'h41 && c[7:0] <= 8'h5A);
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(logic [8:0] c);
    logic [4:0] h;
    h = 5'd0;
    if (is_digit(c)) h = {1'b1, 4'(c[7:0] - 8'h30)};
    else if (!c[8] && c[7:0] >= 8'h61 && c[7:0] <= 8'h66) h = {1'b1, 4'(c[7:0] - 8'h57)};
    else if (!c[8] && c[7:0] >= 8'h41 && c[7:0] <= 8'h46) h = {1'b1, 4'(c[7:0] - 8'h37)};
    return h;
  endfunction

endpackage

### rtl/core/slt_scan.sv
// Scanner automaton state and the combinational step for one source word.
// Uses slt_pkg for codes, the keyword table and the result bundle type.
`timescale 1ns / 1ps

module slt_scan #(
  parameter int unsigned KEYWORD_CHARS = slt_pkg::KeywordCharsDefault,
  parameter int unsigned POSITION_BITS = slt_pkg::PositionBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 kind_i,
  input  logic [7:0]           char_i,
  output slt_pkg::res_bundle_t bundle_o
);
  import slt_pkg::*;

  localparam int unsigned WLW = $clog2(KEYWORD_CHARS + 2);
  localparam int unsigned WIW = $clog2(KEYWORD_CHARS);
  localparam int unsigned PB  = POSITION_BITS;

  typedef struct packed {
    scan_state_e                      st;
    logic [KEYWORD_CHARS-1:0][7:0]    wbuf;
    logic [WLW-1:0]                   wlen;
    logic                             wspec;
    logic [3:0]                       hex;
    logic                             halted;
    logic [5:0]                       cur;
  } scan_t;

  typedef struct packed {
    scan_t      s;
    logic       again;
    logic       emit;
    logic [1:0] rkind;
    logic [5:0] ttype;
    logic [7:0] vbyte;
  } pass_t;

  typedef struct packed {
    scan_t           s;
    logic [1:0]      n;
    res_t [2:0]      rec;
  } run_t;

  scan_state_e                   st_q, st_d;
  logic [KEYWORD_CHARS-1:0][7:0] wbuf_q, wbuf_d;
  logic [WLW-1:0]                wlen_q, wlen_d;
  logic                          wspec_q, wspec_d;
  logic [3:0]                    hex_q, hex_d;
  logic                          halted_q, halted_d;
  logic [5:0]                    cur_q, cur_d;
  logic [PB-1:0]                 line_q, line_d;
  logic [PB-1:0]                 col_q, col_d;
  logic                          als_q, als_d;
  logic                          pnl_q, pnl_d;

  function automatic logic [15:0] clip16(logic [PB-1:0] v);
    logic [PB+15:0] w;
    w = {16'b0, v};
    return (w > (PB+16)'(16'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic scan_t add_word(scan_t s, logic [7:0] c);
    scan_t r;
    r = s;
    if (s.wlen < WLW'(KEYWORD_CHARS)) r.wbuf[s.wlen[WIW-1:0]] = c;
    if (s.wlen <= WLW'(KEYWORD_CHARS)) r.wlen = s.wlen + 1'b1;
    return r;
  endfunction

  function automatic logic [5:0] resolve(scan_t s);
    logic [5:0] t;
    logic       m;
    t = T_IDENT;
    if (!s.wspec && s.wlen <= WLW'(KEYWORD_CHARS)) begin
      for (int i = NumKeywords - 1; i >= 0; i--) begin
        m = (s.wlen == WLW'(KW_LEN[i]));
        for (int j = 0; j < 6; j++) begin
          if (j < int'(KW_LEN[i]) && s.wbuf[j] != KW_TXT[i][47-8*j -: 8]) m = 1'b0;
        end
        if (m) t = T_KEY0 + 6'(i);
      end
    end
    return t;
  endfunction

  function automatic pass_t scan_pass(scan_t s, logic [8:0] c, logic col_one);
    pass_t      r;
    logic       dp, df, dfl;
    logic [7:0] pb;
    logic [5:0] ft;
    logic [4:0] h;
    r = '0;
    r.s = s;
    dp = 1'b0;
    df = 1'b0;
    dfl = 1'b0;
    pb = c[7:0];
    ft = T_IDENT;
    h = hex_val(c);
    unique case (s.st)
      S_START: begin
        case (c)
          C_MINUS: begin df = 1'b1; ft = T_MINUS; end
          C_PLUS:  begin df = 1'b1; ft = T_PLUS; end
          C_COMMA: begin df = 1'b1; ft = T_COMMA; end
          C_RPAR:  begin df = 1'b1; ft = T_RBR; end
          C_LPAR:  begin df = 1'b1; ft = T_LBR; end
          C_STAR:  begin df = 1'b1; ft = T_STAR; end
          C_SLASH: begin df = 1'b1; ft = T_SLASH; end
          C_GT:    begin r.s.cur = T_MORE; r.s.st = S_MORE; end
          C_LT:    begin r.s.cur = T_LESS; r.s.st = S_LESS; end
          C_EQ: begin
            // block comment opens only in the first column
            if (col_one) r.s.st = S_BC_B;
            else begin
              r.s.cur = T_EQUAL;
              r.s.st = S_EQUAL;
            end
          end
          C_BANG:  begin r.s.cur = T_NOT_EQ; r.s.st = S_NOTEQ; end
          C_HASH:  r.s.st = S_LCOMMENT;
          C_QUOTE: begin r.s.cur = T_STRING; r.s.st = S_STRING; end
          C_NL:    begin df = 1'b1; ft = T_NEWLINE; end
          C_END:   begin df = 1'b1; ft = T_EOF; end
          C_SPACE, C_TAB: ;
          default: begin
            if (c == C_UNDER || is_lower(c)) begin
              r.s.cur = T_IDENT;
              r.s.wlen = '0;
              r.s.wspec = 1'b0;
              r.s = add_word(r.s, c[7:0]);
              dp = 1'b1;
              r.s.st = S_IDENT;
            end else if (is_digit(c)) begin
              r.s.cur = T_INT;
              dp = 1'b1;
              r.s.st = S_INT;
            end else begin
              dfl = 1'b1;
            end
          end
        endcase
      end
      S_IDENT: begin
        if (is_word(c)) begin
          r.s = add_word(r.s, c[7:0]);
          dp = 1'b1;
        end else if (c == C_QMARK || c == C_BANG) begin
          r.s.wspec = 1'b1;
          dp = 1'b1;
          r.s.st = S_IDCHECK;
        end else begin
          df = 1'b1;
          r.again = 1'b1;
        end
      end
      S_IDCHECK: begin
        if (is_word(c) || c == C_QMARK) dfl = 1'b1;
        else begin
          df = 1'b1;
          r.again = 1'b1;
        end
      end
      S_LESS: begin
        df = 1'b1;
        if (c == C_EQ) ft = T_LESS_EQ;
        else begin
          ft = T_LESS;
          r.again = 1'b1;
        end
      end
      S_MORE: begin
        df = 1'b1;
        if (c == C_EQ) ft = T_MORE_EQ;
        else begin
          ft = T_MORE;
          r.again = 1'b1;
        end
      end
      S_EQUAL: begin
        df = 1'b1;
        if (c == C_EQ) ft = T_EQUAL2;
        else begin
          ft = T_EQUAL;
          r.again = 1'b1;
        end
      end
      S_NOTEQ: begin
        if (c == C_EQ) begin df = 1'b1; ft = T_NOT_EQ; end
        else dfl = 1'b1;
      end
      S_LCOMMENT: begin
        if (c == C_NL) begin df = 1'b1; ft = T_NEWLINE; end
        else if (c == C_END) begin df = 1'b1; ft = T_EOF; end
      end
      S_INT: begin
        if (is_digit(c)) dp = 1'b1;
        else if (c == C_DOT) begin
          r.s.cur = T_DOUBLE;
          dp = 1'b1;
          r.s.st = S_DOT;
        end else if (c == C_E || c == C_UPPERE) begin
          r.s.cur = T_DOUBLE;
          dp = 1'b1;
          pb = C_E[7:0];
          r.s.st = S_EXPMARK;
        end else begin
          df = 1'b1;
          ft = s.cur;
          r.again = 1'b1;
        end
      end
      S_DOT: begin
        if (is_digit(c)) begin dp = 1'b1; r.s.st = S_FRAC; end
        else dfl = 1'b1;
      end
      S_FRAC: begin
        if (is_digit(c)) dp = 1'b1;
        else if (c == C_E || c == C_UPPERE) begin
          dp = 1'b1;
          pb = C_E[7:0];
          r.s.st = S_EXPMARK;
        end else begin
          df = 1'b1;
          ft = s.cur;
          r.again = 1'b1;
        end
      end
      S_EXPMARK: begin
        if (is_digit(c)) begin dp = 1'b1; r.s.st = S_EXP; end
        else if (c == C_PLUS || c == C_MINUS) begin dp = 1'b1; r.s.st = S_EXPSIGN; end
        else dfl = 1'b1;
      end
      S_EXPSIGN: begin
        if (is_digit(c)) begin dp = 1'b1; r.s.st = S_EXP; end
        else dfl = 1'b1;
      end
      S_EXP: begin
        if (is_digit(c)) dp = 1'b1;
        else begin
          df = 1'b1;
          ft = s.cur;
          r.again = 1'b1;
        end
      end
      S_STRING: begin
        if (c == C_QUOTE) begin df = 1'b1; ft = T_STRING; end
        else if (c == C_BSLASH) r.s.st = S_ESC;
        else if (c[8] || c[7:5] == 3'b000) dfl = 1'b1;
        else dp = 1'b1;
      end
      S_ESC: begin
        r.s.st = S_STRING;
        case (c)
          C_QUOTE:  dp = 1'b1;
          C_N:      begin dp = 1'b1; pb = C_NL[7:0]; end
          C_T:      begin dp = 1'b1; pb = C_TAB[7:0]; end
          C_S:      begin dp = 1'b1; pb = C_SPACE[7:0]; end
          C_BSLASH: dp = 1'b1;
          C_X:      r.s.st = S_HEX;
          default:  dfl = 1'b1;
        endcase
      end
      S_HEX: begin
        if (!h[4]) dfl = 1'b1;
        else begin
          r.s.hex = h[3:0];
          r.s.st = S_HEX1;
        end
      end
      S_HEX1: begin
        r.s.st = S_STRING;
        dp = 1'b1;
        if (h[4]) pb = {s.hex, h[3:0]};
        else begin
          // one digit only: emit it and rescan the byte inside the string
          pb = {4'h0, s.hex};
          r.again = 1'b1;
        end
      end
      S_BC_B: if (c == C_B) r.s.st = S_BC_E; else dfl = 1'b1;
      S_BC_E: if (c == C_E) r.s.st = S_BC_G; else dfl = 1'b1;
      S_BC_G: if (c == C_G) r.s.st = S_BC_I; else dfl = 1'b1;
      S_BC_I: if (c == C_I) r.s.st = S_BC_N; else dfl = 1'b1;
      S_BC_N: if (c == C_N) r.s.st = S_BC_SPACE; else dfl = 1'b1;
      S_BC_SPACE: begin
        if (c == C_SPACE || c == C_TAB) r.s.st = S_BC_BODY;
        else if (c == C_NL) r.s.st = S_BC_ENDCHK;
        else dfl = 1'b1;
      end
      S_BC_BODY: begin
        if (c == C_END) dfl = 1'b1;
        else if (c == C_NL) r.s.st = S_BC_ENDCHK;
      end
      S_BC_ENDCHK: begin
        if (c == C_EQ) r.s.st = S_BC_E2;
        else begin r.s.st = S_BC_BODY; r.again = 1'b1; end
      end
      S_BC_E2: begin
        if (c == C_E) r.s.st = S_BC_N2;
        else begin r.s.st = S_BC_BODY; r.again = 1'b1; end
      end
      S_BC_N2: begin
        if (c == C_N) r.s.st = S_BC_D2;
        else begin r.s.st = S_BC_BODY; r.again = 1'b1; end
      end
      S_BC_D2: begin
        if (c == C_D) r.s.st = S_BC_SPACE2;
        else begin r.s.st = S_BC_BODY; r.again = 1'b1; end
      end
      S_BC_SPACE2: begin
        if (c == C_SPACE || c == C_TAB) r.s.st = S_BC_TAIL;
        else if (c == C_NL) begin df = 1'b1; ft = T_NEWLINE; end
        else if (c == C_END) begin df = 1'b1; ft = T_EOF; end
        else r.s.st = S_BC_BODY;
      end
      S_BC_TAIL: begin
        if (c == C_NL) begin df = 1'b1; ft = T_NEWLINE; end
        else if (c == C_END) begin df = 1'b1; ft = T_EOF; end
      end
      S_DONE: ;
      default: begin
        r.s.st = S_START;
        r.again = 1'b1;
      end
    endcase
    r.emit = dp | df | dfl;
    if (dfl) begin
      r.rkind = RK_ERROR;
      r.ttype = T_IDENT;
      r.vbyte = c[8] ? 8'h00 : c[7:0];
      r.s.halted = 1'b1;
      r.again = 1'b0;
    end else if (df) begin
      r.rkind = RK_TOKEN;
      r.ttype = (ft == T_IDENT) ? resolve(r.s) : ft;
      r.vbyte = 8'h00;
      r.s.st = S_START;
    end else begin
      r.rkind = RK_PAYLOAD;
      r.ttype = r.s.cur;
      r.vbyte = pb;
    end
    return r;
  endfunction

  // up to three passes over one byte, stamping each result with the position
  function automatic run_t run3(scan_t s, logic [8:0] c, logic [PB-1:0] line,
                                logic [PB-1:0] col);
    run_t  r;
    pass_t p;
    logic  going;
    r = '0;
    r.s = s;
    going = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (going && !r.s.halted) begin
        p = scan_pass(r.s, c, col == PB'(1));
        r.s = p.s;
        if (p.emit) begin
          r.rec[r.n].rkind = p.rkind;
          r.rec[r.n].ttype = p.ttype;
          r.rec[r.n].vbyte = p.vbyte;
          r.rec[r.n].line  = clip16(line);
          r.rec[r.n].col   = clip16(col);
          r.rec[r.n].last  = 1'b0;
          r.n = r.n + 1'b1;
        end
        going = p.again;
      end
    end
    return r;
  endfunction

  scan_t       v;
  run_t        rr;
  res_bundle_t b;
  logic [2:0]  n;

  always_comb begin
    v = '{st: st_q, wbuf: wbuf_q, wlen: wlen_q, wspec: wspec_q, hex: hex_q,
          halted: halted_q, cur: cur_q};
    line_d = line_q;
    col_d = col_q;
    als_d = als_q;
    pnl_d = pnl_q;
    b = '0;
    n = 3'd0;
    rr = '0;
    if (!halted_q && st_q != S_DONE) begin
      if (!kind_i || !pnl_q) begin
        // consume a byte, or the newline supplied before end of input
        if (als_d) begin
          col_d = '0;
          if (pnl_d && line_d != '1) line_d = line_d + 1'b1;
          als_d = 1'b0;
        end
        if (col_d != '1) col_d = col_d + 1'b1;
        pnl_d = kind_i ? 1'b1 : (char_i == C_NL[7:0]);
        if (pnl_d) als_d = 1'b1;
        rr = run3(v, kind_i ? C_NL : {1'b0, char_i}, line_d, col_d);
        v = rr.s;
        for (int k = 0; k < 3; k++) begin
          if (2'(k) < rr.n) begin
            b.rec[n[1:0]] = rr.rec[k];
            n = n + 1'b1;
          end
        end
      end
      if (kind_i && !v.halted) begin
        if (line_d != '1) line_d = line_d + 1'b1;
        col_d = '0;
        als_d = 1'b0;
        rr = run3(v, C_END, line_d, col_d);
        v = rr.s;
        for (int k = 0; k < 3; k++) begin
          if (2'(k) < rr.n && n < 3'(MaxRes)) begin
            b.rec[n[1:0]] = rr.rec[k];
            n = n + 1'b1;
          end
        end
        if (!v.halted) v.st = S_DONE;
      end
    end
    if (n != 3'd0) b.rec[2'(n - 1'b1)].last = 1'b1;
    b.count = n;
    st_d = v.st;
    wbuf_d = v.wbuf;
    wlen_d = v.wlen;
    wspec_d = v.wspec;
    hex_d = v.hex;
    halted_d = v.halted;
    cur_d = v.cur;
  end

  assign bundle_o = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_START;
      wlen_q <= '0;
      wspec_q <= 1'b0;
      hex_q <= 4'h0;
      halted_q <= 1'b0;
      cur_q <= T_IDENT;
      line_q <= PB'(1);
      col_q <= '0;
      als_q <= 1'b1;
      pnl_q <= 1'b0;
    end else if (adv_i) begin
      st_q <= st_d;
      wlen_q <= wlen_d;
      wspec_q <= wspec_d;
      hex_q <= hex_d;
      halted_q <= halted_d;
      cur_q <= cur_d;
      line_q <= line_d;
      col_q <= col_d;
      als_q <= als_d;
      pnl_q <= pnl_d;
    end
  end

  // word text needs no reset: only entries written in the current word are read
  always_ff @(posedge clk_i) begin
    if (adv_i) wbuf_q <= wbuf_d;
  end

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q && $stable(st_q)) else $error("scanner left halt");
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b.count != 3'd0 && halted_d && !halted_q) |->
      b.rec[2'(b.count - 1'b1)].rkind == RK_ERROR) else $error("error not final");
  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DONE || halted_q) |-> b.count == 3'd0) else $error("result after end");
`endif

endmodule

### rtl/core/slt_outq.sv
// Result queue: holds one item's words, drains one per cycle while ready_i is set.
// Uses slt_pkg for the result record and bundle types.
`timescale 1ns / 1ps

module slt_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  slt_pkg::res_bundle_t bundle_i,
  output logic                 free_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output slt_pkg::res_t        rec_o
);
  import slt_pkg::*;

  res_t [MaxRes-1:0] rec_q;
  logic [2:0]        cnt_q;
  logic [2:0]        idx_q;
  logic              take;

  assign valid_o = (idx_q != cnt_q);
  assign take    = valid_o && ready_i;
  assign free_o  = !valid_o || (ready_i && (idx_q + 1'b1 == cnt_q));
  assign rec_o   = rec_q[idx_q[1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      idx_q <= 3'd0;
    end else if (load_i) begin
      cnt_q <= bundle_i.count;
      idx_q <= 3'd0;
    end else if (take) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) rec_q <= bundle_i.rec;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(MaxRes) && idx_q <= cnt_q) else $error("queue index out of range");
  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (rec_o.last == (idx_q + 1'b1 == cnt_q))) else $error("last misplaced");
  a_load_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o) else $error("load over pending words");
`endif

endmodule

### rtl/core/source_lexer_token_fsm.sv
// Top level of the source scanner: input word register, scanner step, result queue.
// Depends on slt_pkg, slt_scan and slt_outq.
`timescale 1ns / 1ps

// Source scanner. Each input word carries one source byte (tuser low) or the end-of-input
// mark (tuser high). The byte is held in an input register and, in the cycle it leaves it,
// runs through the whole automaton step, which yields zero to four result words into a
// result queue. The queue drains one word per cycle while the output is ready, and takes
// the next item as its last word leaves; items that yield at most one word stream at one
// per cycle while the output is ready. After a lexical error or after end of input the block
// gives no more words until reset. There is no clearing pass after reset.
module source_lexer_token_fsm #(
  parameter int unsigned KEYWORD_CHARS = slt_pkg::KeywordCharsDefault,
  parameter int unsigned POSITION_BITS = slt_pkg::PositionBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_byte
  input  logic        s_axis_tuser_i,   // [0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [5:0] token_type, [13:6] value_byte,
                                        // [29:14] line_no, [45:30] column_no, zero above
  output logic [1:0]  m_axis_tuser_o,   // [1:0] result_kind
  output logic        m_axis_tlast_o
);
  import slt_pkg::*;

  logic        in_vld_q;
  logic        in_kind_q;
  logic [7:0]  in_char_q;
  logic        q_free;
  logic        adv;
  res_bundle_t bundle;
  res_t        rec;

  assign adv             = in_vld_q && q_free;
  assign s_axis_tready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_kind_q <= s_axis_tuser_i;
      in_char_q <= s_axis_tdata_i;
    end
  end

  slt_scan #(
    .KEYWORD_CHARS(KEYWORD_CHARS),
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .kind_i  (in_kind_q),
    .char_i  (in_char_q),
    .bundle_o(bundle)
  );

  slt_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv),
    .bundle_i(bundle),
    .free_o  (q_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .rec_o   (rec)
  );

  assign m_axis_tdata_o = {2'b00, rec.col, rec.line, rec.vbyte, rec.ttype};
  assign m_axis_tuser_o = rec.rkind;
  assign m_axis_tlast_o = rec.last;

endmodule
